FILE: hw/rtl/avg_pkg.sv
// ----------------------------------------------------------------------------
// avg_pkg
// shared types, constants and tables of the arc vertex generator
// ----------------------------------------------------------------------------
package avg_pkg;

  // segment count limits
  localparam int MAX_SEGMENTS = 4095;
  localparam int MIN_SEGMENTS = 4;

  // cordic depth, one rotation per stage
  localparam int CORDIC_STEPS = 24;

  // angle constants, radians in q4.28
  localparam longint PI_Q      = 64'sd843314857;
  localparam longint TWO_PI_Q  = 2 * PI_Q;
  localparam longint HALF_PI_Q = 64'sd421657428;
  localparam longint GAIN_Q30  = 64'sd652032874;

  // segment count: n = floor(span * spt * SEG_MUL / (SEG_DIV * 2^28))
  localparam longint SEG_MUL     = 64'sd50000;
  localparam longint SEG_DIV     = 64'sd314159;
  localparam int     RECIP_SHIFT = 50;
  localparam longint SEG_RECIP   = ((64'sd1 <<< RECIP_SHIFT) / SEG_DIV) + 64'sd1;
  localparam longint SAT_M       = MAX_SEGMENTS * SEG_DIV;

  // angle divider: 32 quotient bits, a few per stage
  localparam int QUOT_W         = 32;
  localparam int DIV_PER_STAGE  = 4;
  localparam int DIV_STAGES     = QUOT_W / DIV_PER_STAGE;

  // offset that makes every angle positive before the modulo
  localparam longint ANGLE_OFFSET = 7 * TWO_PI_Q;

  // sideband pipe slots, slot 0 is the stage that resolves n
  localparam int K_T        = DIV_STAGES + 1;
  localparam int K_RED      = K_T + 1;
  localparam int RED_STAGES = 4;
  localparam int K_COR      = K_RED + RED_STAGES;
  localparam int K_FLIP     = K_COR + CORDIC_STEPS;
  localparam int K_MUL      = K_FLIP + 1;
  localparam int SIDE_LEN   = K_MUL + 1;

  // register map, word index
  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_START      = 3'd4,
    REG_END        = 3'd5,
    REG_SEG_TURN   = 3'd6
  } reg_idx_t;

  // per-item control that rides along the pipe
  typedef struct packed {
    logic        vld;
    logic [11:0] idx;
    logic [11:0] n;
    logic        oor;
  } side_t;

  // arctangent of 2^-k in q4.28, rounded
  function automatic logic signed [31:0] atan_q28(input int unsigned k);
    logic signed [31:0] r;
    case (k)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      default: begin
        if (k <= 28) begin
          r = 32'sd1 <<< (28 - k);
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/arc_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// arc_vertex_generator_core
// circular arc vertex generator, fixed point, fully pipelined
// ----------------------------------------------------------------------------
// Give a vertex index on the input stream and get back that point of the arc
// set in the registers: x = cx + r*cos t, y = cy + r*sin t, z = cz, with
// t = start + span*i/n and n = max(4, floor(span/(2 pi) * segments_per_turn))
// capped at 4095. The block takes one index every cycle while the output
// is not held and returns each result in order; the depth comes from the
// 8-stage angle divider (4 quotient bits a stage) and the 24-stage cordic,
// plus the segment count, angle reduction and multiply stages. The whole
// pipe advances together and halts only while a finished result waits on
// the output. Registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module arc_vertex_generator_core (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [11:0] vertex_index
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // point_x, point_y, point_z, line_from, segment_count
  output logic         m_tlast,   // is_last
  output logic [1:0]   m_tuser,   // line_present, out_of_range
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import avg_pkg::*;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic signed [31:0] center_x, center_y, center_z, radius;
  logic signed [31:0] start_angle, end_angle;
  logic [10:0]        seg_turn;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      center_z    <= '0;
      radius      <= 32'sd65536;
      start_angle <= '0;
      end_angle   <= 32'(PI_Q);
      seg_turn    <= 11'd64;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X: center_x    <= pwdata;
        REG_CENTER_Y: center_y    <= pwdata;
        REG_CENTER_Z: center_z    <= pwdata;
        REG_RADIUS:   radius      <= pwdata;
        REG_START:    start_angle <= pwdata;
        REG_END:      end_angle   <= pwdata;
        REG_SEG_TURN: seg_turn    <= pwdata[10:0];
        default: ;   // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X: prdata = center_x;
      REG_CENTER_Y: prdata = center_y;
      REG_CENTER_Z: prdata = center_z;
      REG_RADIUS:   prdata = radius;
      REG_START:    prdata = start_angle;
      REG_END:      prdata = end_angle;
      REG_SEG_TURN: prdata = {21'd0, seg_turn};
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipe enable: everything moves unless a result is held on the output
  // --------------------------------------------------------------------------
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // stage 1: span and scaled segments per turn
  logic               v1;
  logic [11:0]        idx1;
  logic signed [32:0] span1;
  logic [26:0]        sptk1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      idx1  <= s_tdata[11:0];
      span1 <= {end_angle[31], end_angle} - {start_angle[31], start_angle};
      sptk1 <= 27'(32'(seg_turn) * 32'(SEG_MUL));
    end
  end

  // stage 2: span * spt * 50000, and the span magnitude
  logic               v2;
  logic [11:0]        idx2;
  logic signed [60:0] b2;
  logic [31:0]        abs2;
  logic               neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      idx2 <= idx1;
      b2   <= span1 * $signed({1'b0, sptk1});
      abs2 <= span1[32] ? 32'(-span1) : 32'(span1);
      neg2 <= span1[32];
    end
  end

  // stage 3: drop the 2^28 scale, form the dividend span*i
  logic               v3;
  logic [11:0]        idx3;
  logic               pos3;
  logic [30:0]        m3;
  logic [43:0]        d3;
  logic               neg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      idx3 <= idx2;
      pos3 <= !b2[60] && (|b2[59:0]);
      m3   <= b2[58:28];
      d3   <= 44'(abs2) * 44'(idx2);
      neg3 <= neg2;
    end
  end

  // stage 4: divide by 314159 through a reciprocal, exact for m below 2^31
  logic               v4;
  logic [11:0]        idx4;
  logic               pos4;
  logic               sat4;
  logic [11:0]        q4;
  logic [43:0]        d4;
  logic               neg4;
  logic [63:0]        recip_prod;

  assign recip_prod = 64'(m3) * 64'(SEG_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ce) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      idx4 <= idx3;
      pos4 <= pos3;
      sat4 <= 64'(m3) >= 64'(SAT_M);
      q4   <= recip_prod[RECIP_SHIFT+11:RECIP_SHIFT];
      d4   <= d3;
      neg4 <= neg3;
    end
  end

  // stage 5: resolve n, range check, load the divider
  side_t       side_p [SIDE_LEN];
  logic [11:0] n_comb;
  logic [11:0] div_rem [DIV_STAGES+1];
  logic [31:0] div_wrk [DIV_STAGES+1];
  logic        div_neg [DIV_STAGES+1];

  always_comb begin
    if (!pos4) begin
      n_comb = 12'(MIN_SEGMENTS);
    end else if (sat4) begin
      n_comb = 12'(MAX_SEGMENTS);
    end else if (q4 < 12'(MIN_SEGMENTS)) begin
      n_comb = 12'(MIN_SEGMENTS);
    end else begin
      n_comb = q4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_p[0] <= '0;
    end else if (ce) begin
      side_p[0].vld <= v4;
      side_p[0].idx <= idx4;
      side_p[0].n   <= n_comb;
      side_p[0].oor <= idx4 > n_comb;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      div_rem[0] <= d4[43:32];
      div_wrk[0] <= d4[31:0];
      div_neg[0] <= neg4;
    end
  end

  // sideband follows the data through every later stage
  for (genvar k = 1; k < SIDE_LEN; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_p[k] <= '0;
      end else if (ce) begin
        side_p[k] <= side_p[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // angle divider: restoring, span*i / n, quotient shifts into the work word
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [11:0] rem_c;
    logic [31:0] wrk_c;

    always_comb begin
      logic [12:0] trial;
      rem_c = div_rem[j];
      wrk_c = div_wrk[j];
      for (int s = 0; s < DIV_PER_STAGE; s++) begin
        trial = {rem_c, wrk_c[31]};
        if (trial >= {1'b0, side_p[j].n}) begin
          rem_c = 12'(trial - {1'b0, side_p[j].n});
          wrk_c = {wrk_c[30:0], 1'b1};
        end else begin
          rem_c = trial[11:0];
          wrk_c = {wrk_c[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        div_rem[j+1] <= rem_c;
        div_wrk[j+1] <= wrk_c;
        div_neg[j+1] <= div_neg[j];
      end
    end
  end

  // angle t = start + signed quotient
  logic signed [33:0] t_q;
  logic signed [33:0] quot_s;

  assign quot_s = div_neg[DIV_STAGES] ? -$signed({2'b00, div_wrk[DIV_STAGES]})
                                      :  $signed({2'b00, div_wrk[DIV_STAGES]});

  always_ff @(posedge clk) begin
    if (ce) begin
      t_q <= {{2{start_angle[31]}}, start_angle} + quot_s;
    end
  end

  // --------------------------------------------------------------------------
  // angle reduction into [-pi/2, pi/2]
  // --------------------------------------------------------------------------
  localparam logic [34:0] TP1 = 35'(TWO_PI_Q);
  localparam logic [34:0] TP2 = 35'(2 * TWO_PI_Q);
  localparam logic [34:0] TP4 = 35'(4 * TWO_PI_Q);
  localparam logic [34:0] TP8 = 35'(8 * TWO_PI_Q);

  logic [34:0] u_off, u_a, u_b;
  logic [34:0] red1, red2;
  logic [30:0] red3;
  logic signed [31:0] z_wrap;
  logic        flip_c;
  logic signed [31:0] fold_c;

  // first: shift positive and take off 8 turns
  always_comb begin
    u_off = 35'($signed({t_q[33], t_q})) + 35'(ANGLE_OFFSET);
    u_a   = (u_off >= TP8) ? u_off - TP8 : u_off;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      red1 <= u_a;
    end
  end

  // then 4 and 2 turns
  always_comb begin
    u_b = (red1 >= TP4) ? red1 - TP4 : red1;
    u_b = (u_b >= TP2) ? u_b - TP2 : u_b;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      red2 <= u_b;
    end
  end

  // last turn, now in [0, 2 pi)
  always_ff @(posedge clk) begin
    if (ce) begin
      red3 <= (red2 >= TP1) ? 31'(red2 - TP1) : red2[30:0];
    end
  end

  // map to (-pi, pi] and fold the outer half circle
  always_comb begin
    z_wrap = $signed({1'b0, red3});
    if (z_wrap > 32'(PI_Q)) begin
      z_wrap = z_wrap - 32'(TWO_PI_Q);
    end
    flip_c = 1'b0;
    fold_c = z_wrap;
    if (z_wrap > 32'(HALF_PI_Q)) begin
      fold_c = z_wrap - 32'(PI_Q);
      flip_c = 1'b1;
    end else if (z_wrap < -32'(HALF_PI_Q)) begin
      fold_c = z_wrap + 32'(PI_Q);
      flip_c = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // cordic rotation, q4.30 vector, one micro-rotation per stage
  // --------------------------------------------------------------------------
  logic signed [33:0] cor_x [CORDIC_STEPS+1];
  logic signed [33:0] cor_y [CORDIC_STEPS+1];
  logic signed [31:0] cor_z [CORDIC_STEPS+1];
  logic               cor_f [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      cor_x[0] <= 34'(GAIN_Q30);
      cor_y[0] <= '0;
      cor_z[0] <= fold_c;
      cor_f[0] <= flip_c;
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cor
    logic signed [33:0] dx, dy;
    logic signed [31:0] ang;

    assign dx  = cor_y[j] >>> j;
    assign dy  = cor_x[j] >>> j;
    assign ang = atan_q28(j);

    always_ff @(posedge clk) begin
      if (ce) begin
        cor_f[j+1] <= cor_f[j];
        if (!cor_z[j][31]) begin
          cor_x[j+1] <= cor_x[j] - dx;
          cor_y[j+1] <= cor_y[j] + dy;
          cor_z[j+1] <= cor_z[j] - ang;
        end else begin
          cor_x[j+1] <= cor_x[j] + dx;
          cor_y[j+1] <= cor_y[j] - dy;
          cor_z[j+1] <= cor_z[j] + ang;
        end
      end
    end
  end

  // undo the half-circle fold
  logic signed [31:0] cos_q, sin_q;

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_q <= cor_f[CORDIC_STEPS] ? 32'(-cor_x[CORDIC_STEPS]) : 32'(cor_x[CORDIC_STEPS]);
      sin_q <= cor_f[CORDIC_STEPS] ? 32'(-cor_y[CORDIC_STEPS]) : 32'(cor_y[CORDIC_STEPS]);
    end
  end

  // scale by radius
  logic signed [63:0] mul_x, mul_y;

  always_ff @(posedge clk) begin
    if (ce) begin
      mul_x <= radius * cos_q;
      mul_y <= radius * sin_q;
    end
  end

  // --------------------------------------------------------------------------
  // output register: round, add centre, pack flags
  // --------------------------------------------------------------------------
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< 29;

  logic signed [63:0] rnd_x, rnd_y;
  side_t              so;
  logic               lp;

  assign rnd_x = (mul_x + ROUND_HALF) >>> 30;
  assign rnd_y = (mul_y + ROUND_HALF) >>> 30;
  assign so    = side_p[K_MUL];
  assign lp    = !so.oor && (so.idx != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= so.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata[31:0]    <= so.oor ? '0 : center_x + rnd_x[31:0];
      m_tdata[63:32]   <= so.oor ? '0 : center_y + rnd_y[31:0];
      m_tdata[95:64]   <= so.oor ? '0 : center_z;
      m_tdata[107:96]  <= lp ? so.idx - 12'd1 : '0;
      m_tdata[119:108] <= so.n;
      m_tlast          <= !so.oor && (so.idx == so.n);
      m_tuser          <= {so.oor, lp};
    end
  end

endmodule

FILE: hw/rtl/avg_checker.sv
// ----------------------------------------------------------------------------
// avg_checker
// port-level checks of the arc vertex generator, bound to the top level
// ----------------------------------------------------------------------------
module avg_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata,
  input logic         m_tlast,
  input logic [1:0]   m_tuser
);

  // pipe comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // index past the arc carries no point and no line
  a_oor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata[107:0] == '0) && !m_tlast && !m_tuser[0])
    else $error("out of range result not cleared");

  // last vertex closes the final line
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0] && !m_tuser[1]
                            && (m_tdata[107:96] == m_tdata[119:108] - 12'd1))
    else $error("last vertex line pair wrong");

  // segment count never below four
  a_min_seg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[119:108] >= 12'd4)
    else $error("segment count below minimum");

endmodule

bind arc_vertex_generator_core avg_checker u_avg_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the arc vertex generator core against a built-in fixed-point model
// of the arc: each vertex index sent is turned into an expected point, line
// pair and flags, and the returned stream is compared in order, field by field,
// over many register settings with random gaps and stalls on both streams
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import avg_pkg::*;

  // expected content of one output transfer
  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [11:0] from_idx;
    logic        has_line;
    logic        last;
    logic        oor;
    logic [11:0] n;
  } vertex_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;   // [11:0] vertex_index
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;        // point_x, point_y, point_z, line_from, segment_count
  logic         m_tlast;        // is_last
  logic [1:0]   m_tuser;        // line_present, out_of_range
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  arc_vertex_generator_core dut (.*);

  always #6 clk = ~clk;

  // register copy used by the predictor
  logic [31:0] arc_regs [7];
  logic [11:0] index_q [$];     // indices waiting to be sent
  vertex_t     vertex_q [$];    // expected vertices in flight
  int          in_gap = 0;
  int          out_wait = 0;
  int          hold_cnt = 0;
  int          out_count = 0;
  bit          calm = 1'b0;     // no random gaps or stalls on either side
  bit          failed = 1'b0;

  function automatic longint atan_step(int k);
    longint tab [10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                         8385879, 4193963, 2097109, 1048571, 524287};
    if (k < 10) return tab[k];
    if (k <= 28) return longint'(1) <<< (28 - k);
    return 0;
  endfunction

  function automatic longint seg_count();
    longint start = longint'($signed(arc_regs[REG_START]));
    longint span = longint'($signed(arc_regs[REG_END])) - start;
    longint prod = span * longint'(arc_regs[REG_SEG_TURN]) * 100000;
    longint n = MIN_SEGMENTS;
    if (prod > 0 && prod / (longint'(628318) <<< 28) > n) n = prod / (longint'(628318) <<< 28);
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    return n;
  endfunction

  // offset a centre by radius * unit component, rounded, wrapping at 32 bits
  function automatic logic [31:0] offset_centre(logic [31:0] c, longint r, longint f);
    longint p = (r * f + (longint'(1) <<< 29)) >>> 30;
    return c + p[31:0];
  endfunction

  function automatic vertex_t arc_vertex(logic [11:0] idx);
    vertex_t v;
    longint i = idx;
    longint start = longint'($signed(arc_regs[REG_START]));
    longint span = longint'($signed(arc_regs[REG_END])) - start;
    longint n = seg_count();
    longint z, x, y, dx, dy, r;
    bit flip = 1'b0;
    v = '{default: '0};
    v.n = n[11:0];
    if (i > n) begin
      v.oor = 1'b1;
      return v;
    end
    // fold the angle into [-pi/2, pi/2]
    z = (start + (span * i) / n) % TWO_PI_Q;
    if (z < 0) z += TWO_PI_Q;
    if (z > PI_Q) z -= TWO_PI_Q;
    if (z > HALF_PI_Q) begin
      z -= PI_Q;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q;
      flip = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(k);
      end else begin
        x += dx; y -= dy; z += atan_step(k);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r = longint'($signed(arc_regs[REG_RADIUS]));
    v.px = offset_centre(arc_regs[REG_CENTER_X], r, x);
    v.py = offset_centre(arc_regs[REG_CENTER_Y], r, y);
    v.pz = arc_regs[REG_CENTER_Z];
    v.has_line = (i > 0);
    v.from_idx = (i > 0) ? idx - 12'd1 : 12'd0;
    v.last = (i == n);
    return v;
  endfunction

  // input side: present queued indices with random gaps between transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        vertex_q.insert(vertex_q.size(), arc_vertex(s_tdata[11:0]));
        void'(index_q.pop_front());
        in_gap = calm ? 0 : $urandom_range(0, 4);
      end
      if (s_tvalid && !s_tready) begin
        // hold the offered transfer
      end else if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (index_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, index_q[0]};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side: check each transfer, stall at random, one long hold-off
  always @(posedge clk) begin
    vertex_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_count++;
        out_wait = calm ? 0 : $urandom_range(0, 4);
        if (out_count == 150) hold_cnt = 300;
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex transfer");
          failed = 1'b1;
        end else begin
          e = vertex_q.pop_front();
          if (m_tdata[31:0] !== e.px) begin
            $error("point_x exp %h got %h", e.px, m_tdata[31:0]); failed = 1'b1;
          end
          if (m_tdata[63:32] !== e.py) begin
            $error("point_y exp %h got %h", e.py, m_tdata[63:32]); failed = 1'b1;
          end
          if (m_tdata[95:64] !== e.pz) begin
            $error("point_z exp %h got %h", e.pz, m_tdata[95:64]); failed = 1'b1;
          end
          if (m_tdata[107:96] !== e.from_idx) begin
            $error("line_from exp %0d got %0d", e.from_idx, m_tdata[107:96]); failed = 1'b1;
          end
          if (m_tdata[119:108] !== e.n) begin
            $error("segment_count exp %0d got %0d", e.n, m_tdata[119:108]); failed = 1'b1;
          end
          if (m_tlast !== e.last) begin
            $error("is_last exp %b got %b", e.last, m_tlast); failed = 1'b1;
          end
          if (m_tuser[0] !== e.has_line) begin
            $error("line_present exp %b got %b", e.has_line, m_tuser[0]); failed = 1'b1;
          end
          if (m_tuser[1] !== e.oor) begin
            $error("out_of_range exp %b got %b", e.oor, m_tuser[1]); failed = 1'b1;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic reg_write(int idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < 7) arc_regs[idx] = (idx == REG_SEG_TURN) ? (val & 32'h7ff) : val;
  endtask

  // wait until every index is sent and every expected vertex is checked, so the pipe is empty
  task automatic drain();
    while (index_q.size() > 0 || vertex_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_arc(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] r,
                         logic [31:0] a0, logic [31:0] a1, logic [31:0] spt);
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_CENTER_Z, cz);
    reg_write(REG_RADIUS, r);
    reg_write(REG_START, a0);
    reg_write(REG_END, a1);
    reg_write(REG_SEG_TURN, spt);
    // unmapped word, must be ignored
    if ($urandom_range(0, 1)) reg_write(7, $urandom);
  endtask

  // mostly indices along the arc, some past its end
  task automatic queue_indices(int cnt);
    int n = int'(seg_count());
    for (int j = 0; j < cnt; j++) begin
      case ($urandom_range(0, 9))
        0: index_q.insert(index_q.size(), 12'($urandom));
        1: index_q.insert(index_q.size(), 12'(n));
        2: index_q.insert(index_q.size(), 12'(n + $urandom_range(1, 3)));
        default: index_q.insert(index_q.size(), 12'($urandom_range(0, n)));
      endcase
    end
  endtask

  initial begin
    arc_regs = '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd843314857, 32'd64};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset arc, index extremes and both ends of the arc
    index_q = '{12'd0, 12'd1, 12'd15, 12'd31, 12'd32, 12'd33, 12'd4095, 12'd2048};
    drain();
    // zero segments per turn, extreme centre and radius
    set_arc(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 32'd0);
    index_q = '{12'd0, 12'd2, 12'd4, 12'd5, 12'd4095};
    drain();
    // widest span and a large segment count, negative radius
    set_arc(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
            32'h80000000, 32'h7fffffff, 32'd1024);
    index_q = '{12'd0, 12'd1, 12'd4094, 12'd4095};
    drain();
    // negative and empty spans
    set_arc(0, 0, 0, 32'd65536, 32'h10000000, 32'hf0000000, 32'd2047);
    index_q = '{12'd0, 12'd3, 12'd4, 12'd5};
    drain();
    set_arc(0, 0, 0, 32'd65536, 32'h20000000, 32'h20000000, 32'd512);
    index_q = '{12'd0, 12'd4, 12'd6};
    drain();

    // random arcs
    for (int ph = 0; ph < 16; ph++) begin
      calm = (ph % 5 == 2);
      case ($urandom_range(0, 3))
        0: set_arc($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 2047));
        default: set_arc($urandom, $urandom, $urandom, $urandom_range(0, 32'h00ffffff),
                         32'($signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000),
                         32'($urandom_range(0, 32'h7fffffff)), $urandom_range(1, 1024));
      endcase
      queue_indices(58);
      drain();
    end

    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
